>>> rtl/urxf_pkg.sv
// Shared types and constants for the UART receiver with receive FIFO.
package urxf_pkg;

    localparam int FIFO_DEPTH_DEF = 64;

    localparam logic [15:0] BIT_PERIOD_RST  = 16'd13020;
    localparam logic [15:0] START_DELAY_RST = 16'(6510 + 13020 / 4);

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = CFG_IDX_W'(1);

    typedef struct packed {
        logic line_level;
        logic clear;
        logic pop_req;
    } in_beat_t;

    typedef struct packed {
        logic       head_valid;
        logic [7:0] head_byte;
        logic       byte_stored;
        logic       byte_dropped;
    } out_beat_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [15:0]          data;
    } cfg_beat_t;

    // Receiver -> FIFO: a finished frame this tick
    typedef struct packed {
        logic       done;
        logic [7:0] data;
    } rx_byte_t;

    // FIFO -> top: per-tick status
    typedef struct packed {
        logic head_valid;
        logic stored;
        logic dropped;
    } fifo_status_t;

endpackage

>>> rtl/urxf_stream_if.sv
// Valid/ready channel carrying one payload beat.
interface urxf_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/urxf_frame.sv
// 8N1 frame receiver: start detect, bit sampling, stop wait.
module urxf_frame (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               line_level,
    input  logic               clear,
    input  logic [15:0]        bit_period,
    input  logic [15:0]        start_delay,
    output urxf_pkg::rx_byte_t rx_byte
);
    import urxf_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [15:0] tick_inc;
    logic [3:0]  bit_idx_reg, bit_idx_next;
    logic [7:0]  shift_reg, shift_next;
    logic        prev_reg, prev_next;
    logic        done;

    assign tick_inc = tick_reg + 16'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        prev_next    = prev_reg;
        done         = 1'b0;
        if (clear)
        begin
            phase_next   = PH_IDLE;
            tick_next    = '0;
            bit_idx_next = '0;
            shift_next   = '0;
            prev_next    = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!line_level && prev_reg)
                    begin
                        phase_next = PH_START;
                        tick_next  = '0;
                    end
                    prev_next = line_level;
                end
                PH_START:
                begin
                    if (tick_reg < start_delay)
                        tick_next = tick_inc;
                    else if (!line_level)
                    begin
                        phase_next   = PH_DATA;
                        tick_next    = '0;
                        bit_idx_next = '0;
                        shift_next   = '0;
                    end
                    else
                        phase_next = PH_IDLE;   // false start
                end
                PH_DATA:
                begin
                    if (tick_inc >= bit_period)
                    begin
                        tick_next = '0;
                        if (line_level)
                            shift_next[bit_idx_reg[2:0]] = 1'b1;
                        bit_idx_next = bit_idx_reg + 4'd1;
                        if (bit_idx_next >= 4'd8)
                            phase_next = PH_STOP;
                    end
                    else
                        tick_next = tick_inc;
                end
                PH_STOP:
                begin
                    // stop level is not checked
                    if (tick_inc >= bit_period)
                    begin
                        tick_next  = '0;
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                        tick_next = tick_inc;
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
            prev_reg    <= 1'b1;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
            prev_reg    <= prev_next;
        end
    end

    assign rx_byte.done = done;
    assign rx_byte.data = shift_reg;

endmodule

>>> rtl/urxf_fifo.sv
// Ring FIFO with one slot kept free; registered head read.
module urxf_fifo #(
    parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   clear,
    input  logic                   pop_req,
    input  urxf_pkg::rx_byte_t     rx_byte,
    output urxf_pkg::fifo_status_t status,
    output logic [7:0]             head_data
);
    import urxf_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [7:0]       mem [FIFO_DEPTH];
    logic [7:0]       rdata_reg;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] wp_inc, rp_inc;
    logic             head_valid;
    logic             full;
    logic             stored;
    logic             dropped;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign wp_inc     = ptr_next(wp_reg);
    assign rp_inc     = ptr_next(rp_reg);
    assign head_valid = (rp_reg != wp_reg);
    // full test uses the tick-start read pointer, even if this tick pops
    assign full       = (wp_inc == rp_reg);
    assign stored     = rx_byte.done && !full;
    assign dropped    = rx_byte.done && full;

    always_comb
    begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        if (clear)
        begin
            wp_next = '0;
            rp_next = '0;
        end
        else
        begin
            if (stored)
                wp_next = wp_inc;
            if (pop_req && head_valid)
                rp_next = rp_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else if (step)
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

    // write goes to wp, read to rp; they differ whenever the head is valid
    always_ff @(posedge clk)
    begin
        if (step)
            rdata_reg <= mem[rp_reg];
        if (step && stored)
            mem[wp_reg] <= rx_byte.data;
    end

    assign status.head_valid = head_valid;
    assign status.stored     = stored;
    assign status.dropped    = dropped;
    assign head_data         = rdata_reg;

endmodule

>>> rtl/uart_receiver_with_fifo_core.sv
// Top level: UART 8N1 receiver with receive FIFO, config registers, output register.
//
//  channel  dir  beat type   contents
//  rx_in    in   in_beat_t   line_level, clear, pop_req (one beat per line sample)
//  rx_out   out  out_beat_t  head_valid, head_byte, byte_stored, byte_dropped
//  cfg      in   cfg_beat_t  index 0 bit_period, 1 start_delay; always ready
//
// One input beat per cycle while rx_in is ready; one result beat per input beat, held
// in the output register (head byte comes from the FIFO memory's read register).
// rx_in is ready whenever the output register is empty or being taken this cycle.
// Reset: receiver idle, FIFO empty, bit_period 13020, start_delay 9765.
// No clearing pass; a FIFO entry is only reported as head after it was written.
module uart_receiver_with_fifo_core #(
    parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    urxf_stream_if.sink   rx_in,
    urxf_stream_if.source rx_out,
    urxf_stream_if.sink   cfg
);
    import urxf_pkg::*;

    logic [15:0]  bit_period_reg;
    logic [15:0]  start_delay_reg;
    logic         step;
    logic         cfg_wr;
    in_beat_t     in_beat;
    cfg_beat_t    cfg_beat;
    rx_byte_t     rx_byte;
    fifo_status_t fifo_status;
    logic [7:0]   head_data;
    logic         out_valid_reg;
    logic         head_valid_reg;
    logic         stored_reg;
    logic         dropped_reg;
    out_beat_t    out_beat;

    assign in_beat     = rx_in.data;
    assign cfg_beat    = cfg.data;
    assign rx_in.ready = !out_valid_reg || rx_out.ready;
    assign step        = rx_in.valid && rx_in.ready;
    assign cfg.ready   = 1'b1;
    assign cfg_wr      = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg  <= BIT_PERIOD_RST;
            start_delay_reg <= START_DELAY_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_beat.index)
                REG_BIT_PERIOD:  bit_period_reg  <= cfg_beat.data;
                REG_START_DELAY: start_delay_reg <= cfg_beat.data;
                default: ;
            endcase
        end
    end

    urxf_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .line_level  (in_beat.line_level),
        .clear       (in_beat.clear),
        .bit_period  (bit_period_reg),
        .start_delay (start_delay_reg),
        .rx_byte     (rx_byte)
    );

    urxf_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .clear     (in_beat.clear),
        .pop_req   (in_beat.pop_req),
        .rx_byte   (rx_byte),
        .status    (fifo_status),
        .head_data (head_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (rx_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            head_valid_reg <= fifo_status.head_valid;
            stored_reg     <= fifo_status.stored;
            dropped_reg    <= fifo_status.dropped;
        end
    end

    assign out_beat.head_valid   = head_valid_reg;
    assign out_beat.head_byte    = head_valid_reg ? head_data : 8'd0;
    assign out_beat.byte_stored  = stored_reg;
    assign out_beat.byte_dropped = dropped_reg;
    assign rx_out.valid          = out_valid_reg;
    assign rx_out.data           = out_beat;

    a_store_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(stored_reg && dropped_reg))
        else $error("byte both stored and dropped");

    a_drop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dropped_reg) |-> head_valid_reg)
        else $error("byte dropped while FIFO reported empty");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_beat.clear) |=> (out_valid_reg && !stored_reg && !dropped_reg))
        else $error("clear beat produced a store or drop");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_beat.clear) ##1 step |=> !head_valid_reg)
        else $error("FIFO not empty after clear");

endmodule

>>> tb/rx_fifo_check.sv
// Checker for the UART receiver with FIFO: tracks receiver state per accepted beat and compares results.
module rx_fifo_check #(
    parameter int DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  urxf_pkg::in_beat_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  urxf_pkg::out_beat_t out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  urxf_pkg::cfg_beat_t cfg_data,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import urxf_pkg::*;

    typedef enum logic [1:0] {RX_IDLE, RX_START, RX_DATA, RX_STOP} rx_phase_t;

    logic [15:0] bit_period;
    logic [15:0] start_delay;

    rx_phase_t   phase;
    logic [15:0] tick_cnt;
    logic [3:0]  bit_idx;
    logic [7:0]  shift_reg;
    logic        prev_level;
    logic [7:0]  fifo_mem [DEPTH];
    int          wr_ptr;
    int          rd_ptr;

    out_beat_t   tick_results_q [$];

    function automatic int next_ptr(int p);
        return (p + 1 == DEPTH) ? 0 : p + 1;
    endfunction

    function automatic void rx_to_idle();
        phase      = RX_IDLE;
        tick_cnt   = '0;
        bit_idx    = '0;
        shift_reg  = '0;
        prev_level = 1'b1;
        wr_ptr     = 0;
        rd_ptr     = 0;
    endfunction

    // One line sample; head is reported from the FIFO as it stood before this tick.
    function automatic out_beat_t step_receiver(in_beat_t b);
        out_beat_t r;
        int        nxt;
        r.head_valid   = (rd_ptr != wr_ptr);
        r.head_byte    = r.head_valid ? fifo_mem[rd_ptr] : 8'h00;
        r.byte_stored  = 1'b0;
        r.byte_dropped = 1'b0;
        if (b.clear)
        begin
            rx_to_idle();
        end
        else
        begin
            case (phase)
                RX_IDLE:
                begin
                    if (!b.line_level && prev_level)
                    begin
                        phase    = RX_START;
                        tick_cnt = '0;
                    end
                    prev_level = b.line_level;
                end
                RX_START:
                begin
                    if (tick_cnt < start_delay)
                        tick_cnt = tick_cnt + 16'd1;
                    else if (!b.line_level)
                    begin
                        phase     = RX_DATA;
                        tick_cnt  = '0;
                        bit_idx   = '0;
                        shift_reg = '0;
                    end
                    else
                        phase = RX_IDLE;   // false start
                end
                RX_DATA:
                begin
                    tick_cnt = tick_cnt + 16'd1;
                    if (tick_cnt >= bit_period)
                    begin
                        tick_cnt = '0;
                        if (b.line_level)
                            shift_reg[bit_idx[2:0]] = 1'b1;
                        bit_idx = bit_idx + 4'd1;
                        if (bit_idx >= 4'd8)
                        begin
                            phase    = RX_STOP;
                            tick_cnt = '0;
                        end
                    end
                end
                default:
                begin
                    // stop level is not checked; full test uses the pre-pop read pointer
                    tick_cnt = tick_cnt + 16'd1;
                    if (tick_cnt >= bit_period)
                    begin
                        nxt      = next_ptr(wr_ptr);
                        tick_cnt = '0;
                        if (nxt != rd_ptr)
                        begin
                            fifo_mem[wr_ptr] = shift_reg;
                            wr_ptr           = nxt;
                            r.byte_stored    = 1'b1;
                        end
                        else
                            r.byte_dropped = 1'b1;
                        phase = RX_IDLE;
                    end
                end
            endcase
            if (b.pop_req && r.head_valid)
                rd_ptr = next_ptr(rd_ptr);
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            rx_to_idle();
            bit_period  = BIT_PERIOD_RST;
            start_delay = START_DELAY_RST;
            for (int i = 0; i < DEPTH; i++)
                fifo_mem[i] = 8'h00;
            tick_results_q.delete();
            errors = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (tick_results_q.size() == 0)
                begin
                    $error("result beat with nothing expected: %p", out_data);
                    errors++;
                end
                else
                begin
                    want = tick_results_q.pop_front();
                    check_field("head_valid", 8'(want.head_valid), 8'(out_data.head_valid));
                    check_field("head_byte", want.head_byte, out_data.head_byte);
                    check_field("byte_stored", 8'(want.byte_stored), 8'(out_data.byte_stored));
                    check_field("byte_dropped", 8'(want.byte_dropped),
                                8'(out_data.byte_dropped));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_data.index)
                    REG_BIT_PERIOD:  bit_period  = cfg_data.data;
                    REG_START_DELAY: start_delay = cfg_data.data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                tick_results_q.push_back(step_receiver(in_data));
        end
        pending = tick_results_q.size();
    end

endmodule

>>> tb/uart_receiver_with_fifo_core_tb.sv
// Testbench top for the UART receiver with FIFO: stimulus, handshake pressure and verdict.
module uart_receiver_with_fifo_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import urxf_pkg::*;

    localparam int RUN_LIMIT = 300000;

    logic clk;
    logic rst_n;

    urxf_stream_if #(.payload_t(in_beat_t))  rx_in_if ();
    urxf_stream_if #(.payload_t(out_beat_t)) rx_out_if ();
    urxf_stream_if #(.payload_t(cfg_beat_t)) cfg_if ();

    int       errors;
    int       pending;
    int       cycles;
    int       send_idle_pct;
    int       take_idle_pct;
    int       stall_len;
    in_beat_t line_q [$];

    uart_receiver_with_fifo_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx_in  (rx_in_if),
        .rx_out (rx_out_if),
        .cfg    (cfg_if)
    );

    rx_fifo_check rx_fifo_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx_in_if.valid),
        .in_ready  (rx_in_if.ready),
        .in_data   (rx_in_if.data),
        .out_valid (rx_out_if.valid),
        .out_ready (rx_out_if.ready),
        .out_data  (rx_out_if.data),
        .cfg_valid (cfg_if.valid),
        .cfg_ready (cfg_if.ready),
        .cfg_data  (cfg_if.data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random back-pressure, plus long holds requested through stall_len
    initial
    begin
        rx_out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_len > 0)
            begin
                stall_len--;
                rx_out_if.ready <= 1'b0;
            end
            else
                rx_out_if.ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic roll(int pct);
        return ($urandom_range(99) < pct);
    endfunction

    function automatic void push_beat(logic level, logic clr, logic pop);
        in_beat_t b;
        b.line_level = level;
        b.clear      = clr;
        b.pop_req    = pop;
        line_q.push_back(b);
    endfunction

    // 8N1 frame, LSB first; only the last beat of each bit period is sampled
    function automatic void push_frame(logic [7:0] data, int period, int delay, int pop_pct,
                                       bit noisy, bit pop_on_stop, int gap);
        int span;
        span = (period < 1) ? 1 : period;
        push_beat(1'b0, 1'b0, roll(pop_pct));
        repeat (delay) push_beat(noisy ? rand_bit() : 1'b0, 1'b0, roll(pop_pct));
        push_beat(1'b0, 1'b0, roll(pop_pct));
        for (int i = 0; i < 8; i++)
        begin
            repeat (span - 1) push_beat(noisy ? rand_bit() : data[i], 1'b0, roll(pop_pct));
            push_beat(data[i], 1'b0, roll(pop_pct));
        end
        repeat (span - 1) push_beat(noisy ? rand_bit() : 1'b1, 1'b0, roll(pop_pct));
        push_beat(1'b1, 1'b0, pop_on_stop ? 1'b1 : roll(pop_pct));
        // idle high re-arms edge detection; no gap leaves the next edge unseen
        repeat (gap) push_beat(1'b1, 1'b0, roll(pop_pct));
    endfunction

    function automatic void push_traffic(int n_beats, int period, int delay, int pop_pct);
        int target;
        int pick;
        int gap;
        target = line_q.size() + n_beats;
        while (line_q.size() < target)
        begin
            pick = $urandom_range(99);
            gap  = ($urandom_range(9) == 0) ? 0 : $urandom_range(3, 1);
            if (pick < 78)
                push_frame(8'($urandom_range(255)), period, delay, pop_pct, pick < 20, 1'b0,
                           gap);
            else if (pick < 86)
            begin
                // false start: line back high at confirmation
                push_beat(1'b1, 1'b0, roll(pop_pct));
                push_beat(1'b0, 1'b0, roll(pop_pct));
                repeat (delay) push_beat(1'b0, 1'b0, roll(pop_pct));
                push_beat(1'b1, 1'b0, roll(pop_pct));
            end
            else if (pick < 92)
            begin
                // frame cut short by clear
                push_beat(1'b1, 1'b0, roll(pop_pct));
                push_beat(1'b0, 1'b0, roll(pop_pct));
                repeat ($urandom_range(8 * period + delay, 1))
                    push_beat(rand_bit(), 1'b0, roll(pop_pct));
                push_beat(rand_bit(), 1'b1, rand_bit());
            end
            else
                repeat ($urandom_range(6, 1)) push_beat(rand_bit(), 1'b0, roll(pop_pct));
        end
    endfunction

    task automatic send_line();
        in_beat_t b;
        while (line_q.size() > 0)
        begin
            b = line_q.pop_front();
            while ($urandom_range(99) < send_idle_pct)
            begin
                rx_in_if.valid <= 1'b0;
                @(negedge clk);
            end
            rx_in_if.valid <= 1'b1;
            rx_in_if.data  <= b;
            @(posedge clk);
            while (!rx_in_if.ready) @(posedge clk);
            @(negedge clk);
        end
        rx_in_if.valid <= 1'b0;
    endtask

    task automatic wait_results();
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_config(logic [15:0] bp, logic [15:0] sd);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: REG_BIT_PERIOD, data: bp};
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        @(negedge clk);
        cfg_if.data <= '{index: REG_START_DELAY, data: sd};
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] bp;
        logic [15:0] sd;
        rx_in_if.valid = 1'b0;
        rx_in_if.data  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;
        send_idle_pct  = 24;
        take_idle_pct  = 24;
        stall_len      = 0;
        rst_n          = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: pop on empty, start edge into the long delay, then clear
        push_beat(1'b1, 1'b0, 1'b1);
        push_beat(1'b0, 1'b0, 1'b0);
        push_beat(1'b1, 1'b1, 1'b1);
        send_line();
        wait_results();

        // below-range settings: sample every beat, confirm on the first start beat
        set_config(16'd0, 16'd0);
        push_frame(8'hFF, 0, 0, 0, 1'b0, 1'b0, 1);
        push_frame(8'h00, 0, 0, 0, 1'b0, 1'b1, 1);   // store and pop in one beat
        push_beat(1'b1, 1'b0, 1'b1);
        push_beat(1'b0, 1'b0, 1'b0);
        push_beat(1'b1, 1'b0, 1'b0);                 // false start
        send_line();
        wait_results();

        // shortest in-range timing, sender pauses midway until all results are back
        set_config(16'd4, 16'd2);
        push_traffic(120, 4, 2, 30);
        send_line();
        wait_results();
        push_traffic(100, 4, 2, 30);
        send_line();
        wait_results();

        // receiver holds off while the sender keeps offering; no random idling here
        bp = 16'($urandom_range(9, 4));
        sd = 16'($urandom_range(9, 2));
        set_config(bp, sd);
        send_idle_pct = 0;
        take_idle_pct = 0;
        stall_len     = 300;
        push_traffic(250, int'(bp), int'(sd), 30);
        send_line();
        wait_results();
        send_idle_pct = 24;
        take_idle_pct = 24;

        // fill the FIFO without pops until bytes drop
        set_config(16'd1, 16'd1);
        repeat (64) push_frame(8'($urandom_range(255)), 1, 1, 0, 1'b0, 1'b0, 1);
        // full: the first of these drops even though its stop beat pops
        repeat (2) push_frame(8'($urandom_range(255)), 1, 1, 0, 1'b0, 1'b1, 1);
        push_traffic(100, 1, 1, 50);
        push_beat(1'b1, 1'b1, 1'b1);
        send_line();
        wait_results();

        // largest register values: frame never completes, clear ends it
        set_config(16'hFFFF, 16'hFFFF);
        push_beat(1'b1, 1'b0, rand_bit());
        push_beat(1'b0, 1'b0, rand_bit());
        repeat (40) push_beat(rand_bit(), 1'b0, rand_bit());
        push_beat(1'b1, 1'b1, 1'b0);
        send_line();
        wait_results();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
